[hw/rtl/scfl_pkg.sv]
package scfl_pkg;

  localparam int unsigned BUCKETS         = 16;
  localparam int unsigned MAX_REUSE_BYTES = 256;
  localparam int unsigned POOL_BLOCKS     = 4096;

  localparam int unsigned SIZE_W    = 16;
  localparam int unsigned ROUND_W   = 17;
  localparam int unsigned HANDLE_W  = 12;
  localparam int unsigned LINK_W    = HANDLE_W + 1;
  localparam int unsigned BIDX_W    = ROUND_W - 4;
  localparam int unsigned BUCKET_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;

  localparam logic [ROUND_W-1:0] ROUND_ADD  = ROUND_W'(15);
  localparam logic [ROUND_W-1:0] ROUND_MASK = ~ROUND_W'(15);

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [2:0] {
    OUT_NULL          = 3'd0,
    OUT_REUSE         = 3'd1,
    OUT_BACKING_ALLOC = 3'd2,
    OUT_KEPT          = 3'd3,
    OUT_BACKING_FREE  = 3'd4
  } outcome_e;

  typedef struct packed {
    logic                en;
    logic [BUCKET_W-1:0] idx;
    logic [HANDLE_W-1:0] head;
    logic                nonempty;
  } bkt_upd_t;

  typedef struct packed {
    logic                en;
    logic [HANDLE_W-1:0] addr;
    logic [LINK_W-1:0]   data;
  } link_wr_t;

endpackage

[hw/rtl/scfl_link_mem.sv]
module scfl_link_mem
  import scfl_pkg::*;
(
  input  logic                clk_i,
  input  logic                rd_en_i,
  input  logic [HANDLE_W-1:0] rd_addr_i,
  output logic [LINK_W-1:0]   rd_data_o,
  input  link_wr_t            wr_i
);

  logic [LINK_W-1:0] mem [POOL_BLOCKS];
  logic [LINK_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[hw/rtl/scfl_bucket_table.sv]
module scfl_bucket_table
  import scfl_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [BUCKET_W-1:0] rd_idx_i,
  output logic [HANDLE_W-1:0] head_o,
  output logic                nonempty_o,
  input  bkt_upd_t            upd_i
);

  logic [HANDLE_W-1:0] head_q     [BUCKETS];
  logic [BUCKETS-1:0]  nonempty_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nonempty_q <= '0;
      for (int i = 0; i < BUCKETS; i++) begin
        head_q[i] <= '0;
      end
    end else if (upd_i.en) begin
      head_q[upd_i.idx]     <= upd_i.head;
      nonempty_q[upd_i.idx] <= upd_i.nonempty;
    end
  end

  assign head_o     = head_q[rd_idx_i];
  assign nonempty_o = nonempty_q[rd_idx_i];

endmodule

[hw/rtl/size_class_free_list_allocator_unit.sv]
// Frees, size-0 and backing requests pass from the input registers (EVAL state)
// to the output register; a reuse pop also passes the POP state and reads the link memory once.
// Throughput: 1 word per cycle without pops while the output is not stalled; a pop
// stalls the input until its link memory read is done. A finished result waits in an output register.
// Reset: asynchronous, active low; all buckets empty, cache disabled, no
// clearing pass (link entries are written before they are read).
module size_class_free_list_allocator_unit
  import scfl_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                cmd_i,
  input  logic [SIZE_W-1:0]   byte_size_i,
  input  logic [HANDLE_W-1:0] block_handle_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [2:0]          outcome_o,
  output logic [HANDLE_W-1:0] result_handle_o,
  output logic [ROUND_W-1:0]  rounded_size_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_POP
  } state_e;

  state_e              state_q;
  logic                cache_en_q;
  logic                cmd_q;
  logic [SIZE_W-1:0]   size_q;
  logic [HANDLE_W-1:0] handle_q;
  logic                out_valid_q;
  outcome_e            outcome_q;
  logic [HANDLE_W-1:0] rhandle_q;
  logic [ROUND_W-1:0]  rounded_q;

  logic [ROUND_W-1:0]  rounded;
  logic [BIDX_W-1:0]   bidx_full;
  logic [BUCKET_W-1:0] bidx;
  logic                hit;
  logic                in_pool;
  logic                head_in_pool;
  logic [HANDLE_W-1:0] head;
  logic                nonempty;
  logic [LINK_W-1:0]   link_rd;
  logic [LINK_W-1:0]   link;
  logic                is_pop;
  logic                out_free;
  logic                done;
  logic                accept;
  logic                rd_en;
  outcome_e            outcome_d;
  logic [HANDLE_W-1:0] rhandle_d;
  bkt_upd_t            upd;
  link_wr_t            link_wr;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cache_en_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      cache_en_q <= cfg_data_i;
    end
  end

  assign rounded   = (ROUND_W'(size_q) + ROUND_ADD) & ROUND_MASK;
  assign bidx_full = rounded[ROUND_W-1:4] - BIDX_W'(1);
  assign bidx      = bidx_full[BUCKET_W-1:0];
  assign hit       = cache_en_q && (size_q != '0)
                     && (rounded <= ROUND_W'(MAX_REUSE_BYTES))
                     && (bidx_full < BIDX_W'(BUCKETS));
  assign in_pool      = (ROUND_W'(handle_q) < ROUND_W'(POOL_BLOCKS));
  assign head_in_pool = (ROUND_W'(head) < ROUND_W'(POOL_BLOCKS));
  assign link         = head_in_pool ? link_rd : '0;

  assign is_pop   = (cmd_q == CMD_ALLOC) && hit && nonempty;
  assign out_free = !out_valid_q || !out_stall_i;
  assign done     = out_free && (((state_q == ST_EVAL) && !is_pop) || (state_q == ST_POP));
  assign in_stall_o = !((state_q == ST_IDLE) || done);
  assign accept     = in_valid_i && !in_stall_o;
  assign rd_en      = (state_q == ST_EVAL) && is_pop;

  always_comb begin
    outcome_d = OUT_NULL;
    rhandle_d = '0;
    upd       = '0;
    link_wr   = '0;
    upd.idx   = bidx;
    link_wr.addr = handle_q;
    link_wr.data = {nonempty, head};
    if (state_q == ST_POP) begin
      outcome_d    = OUT_REUSE;
      rhandle_d    = head;
      upd.en       = done;
      upd.head     = link[HANDLE_W-1:0];
      upd.nonempty = link[LINK_W-1];
    end else if (cmd_q == CMD_ALLOC) begin
      outcome_d = (size_q == '0) ? OUT_NULL : OUT_BACKING_ALLOC;
    end else begin
      rhandle_d = handle_q;
      if (hit && in_pool) begin
        outcome_d    = OUT_KEPT;
        upd.en       = done;
        upd.head     = handle_q;
        upd.nonempty = 1'b1;
        link_wr.en   = done;
      end else begin
        outcome_d = OUT_BACKING_FREE;
      end
    end
  end

  scfl_bucket_table u_bucket_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_idx_i   (bidx),
    .head_o     (head),
    .nonempty_o (nonempty),
    .upd_i      (upd)
  );

  scfl_link_mem u_link_mem (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (head),
    .rd_data_o (link_rd),
    .wr_i      (link_wr)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cmd_q       <= CMD_ALLOC;
      size_q      <= '0;
      handle_q    <= '0;
      out_valid_q <= 1'b0;
      outcome_q   <= OUT_NULL;
      rhandle_q   <= '0;
      rounded_q   <= '0;
    end else begin
      if (accept) begin
        cmd_q    <= cmd_i;
        size_q   <= byte_size_i;
        handle_q <= block_handle_i;
      end
      if (done) begin
        out_valid_q <= 1'b1;
        outcome_q   <= outcome_d;
        rhandle_q   <= rhandle_d;
        rounded_q   <= rounded;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          if (is_pop) begin
            state_q <= ST_POP;
          end else if (done) begin
            state_q <= accept ? ST_EVAL : ST_IDLE;
          end
        end
        ST_POP: begin
          if (done) begin
            state_q <= accept ? ST_EVAL : ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign outcome_o       = outcome_q;
  assign result_handle_o = rhandle_q;
  assign rounded_size_o  = rounded_q;

  a_pop_follows_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_POP) |-> ($past(state_q) == ST_EVAL || $past(state_q) == ST_POP))
    else $error("pop state entered without evaluation");

  a_accept_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (state_q != ST_IDLE)) |-> done)
    else $error("word accepted while previous word in flight");

  a_reuse_needs_cache: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done && (state_q == ST_POP)) |-> cache_en_q)
    else $error("reuse completed with cache disabled");

  a_push_in_pool: assert property (@(posedge clk_i) disable iff (!rst_ni)
    link_wr.en |-> (in_pool && upd.en && (cmd_q == CMD_FREE)))
    else $error("link write without matching bucket push");

endmodule
